FILE: hw/rtl/preview_frame_pacer_core_macros.svh
// Assertion macros for the preview frame pacer.
// Included by the top level; depends on clk and rst_n in the including scope.
`ifndef PREVIEW_FRAME_PACER_CORE_MACROS_SVH
`define PREVIEW_FRAME_PACER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Implication in the same cycle.
`define PFP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pacer assertion failed");
// Implication in the next cycle.
`define PFP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pacer assertion failed");
`else
`define PFP_ASSERT_IMP(label, ante, cons)
`define PFP_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: hw/rtl/pfp_pkg.sv
// Shared types and constants of the preview frame pacer.
// No dependencies; used by every module of the block.
package pfp_pkg;

    // Pending buffer queue geometry.
    localparam int QUEUE_DEPTH = 8;
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Field widths.
    localparam int TIME_W  = 63;
    localparam int XFORM_W = 8;
    localparam int BUFID_W = 32;
    localparam int FENCE_W = 21;
    localparam int WM_W    = 3;
    localparam int SPACE_W = 32;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // Register reset values.
    localparam logic [WM_W-1:0]    WM_RESET    = 3'd1;
    localparam logic [SPACE_W-1:0] SPACE_RESET = 32'd1000000000;

    // Largest presentation time, used when the ideal time saturates.
    localparam logic [63:0] TIME_MAX = {1'b0, {63{1'b1}}};

    typedef enum logic {
        REG_WATERMARK = 1'b0,
        REG_SPACING   = 1'b1
    } reg_idx_t;

    typedef enum logic {
        CMD_QUEUE = 1'b0,
        CMD_CAND  = 1'b1
    } cmd_kind_t;

    typedef enum logic [1:0] {
        RUN_IDLE  = 2'd0,
        RUN_HELD  = 2'd1,
        RUN_EMPTY = 2'd2
    } run_t;

    typedef enum logic [2:0] {
        BK_IDLE   = 3'd0,
        BK_EXEC   = 3'd1,
        BK_TARGET = 3'd2,
        BK_GAP    = 3'd3,
        BK_UPDATE = 3'd4
    } bk_state_t;

    // One pending buffer.
    typedef struct packed {
        logic [TIME_W-1:0]         time_ns;
        logic [BUFID_W-1:0]        buf_id;
        logic [XFORM_W-1:0]        transform;
        logic signed [FENCE_W-1:0] fence;
    } entry_t;

    // One classified item on its way to the back end.
    typedef struct packed {
        cmd_kind_t                 kind;
        logic [TIME_W-1:0]         time_ns;
        logic [XFORM_W-1:0]        transform;
        logic [BUFID_W-1:0]        buf_id;
        logic signed [FENCE_W-1:0] fence;
        logic                      last;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic [BUFID_W-1:0]        buf_id;
        logic [XFORM_W-1:0]        transform;
        logic signed [FENCE_W-1:0] fence;
        logic [TIME_W-1:0]         time_ns;
        logic                      early;
    } res_t;

    // Back end status seen by the top level.
    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              held;
    } bk_stat_t;

endpackage

FILE: hw/rtl/pfp_front.sv
// Front end of the pacer: accepts items, classifies them and queues them.
// Depends on pfp_pkg.
module pfp_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                func,
    input  logic [pfp_pkg::TIME_W-1:0]          time_ns,
    input  logic [pfp_pkg::XFORM_W-1:0]         frame_transform,
    input  logic [pfp_pkg::BUFID_W-1:0]         buffer_id,
    input  logic signed [pfp_pkg::FENCE_W-1:0]  fence_id,
    input  logic                                last_candidate,
    output logic                                cmd_valid,
    output pfp_pkg::cmd_t                       cmd,
    input  logic                                cmd_take
);

    pfp_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;
    logic          do_push;
    logic          do_pop;
    pfp_pkg::cmd_t in_cmd;

    // Classify the incoming item.
    always_comb
    begin
        in_cmd.kind      = func ? pfp_pkg::CMD_CAND : pfp_pkg::CMD_QUEUE;
        in_cmd.time_ns   = time_ns;
        in_cmd.transform = frame_transform;
        in_cmd.buf_id    = buffer_id;
        in_cmd.fence     = fence_id;
        in_cmd.last      = last_candidate;
    end

    // Two-entry queue toward the back end.
    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Slot payload carries no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: hw/rtl/pfp_res_q.sv
// Result queue of the pacer: holds finished items until they are popped.
// Depends on pfp_pkg.
module pfp_res_q (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_push,
    input  pfp_pkg::res_t res_data,
    output logic          res_full,
    output logic          empty,
    input  logic          pop,
    output pfp_pkg::res_t head
);

    pfp_pkg::res_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;
    logic          do_push;
    logic          do_pop;

    assign res_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign head     = slot_reg[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= res_data;
        end
    end

endmodule

FILE: hw/rtl/pfp_back.sv
// Back end of the pacer: pending buffer store, run tracking and pacing math.
// Depends on pfp_pkg; fed by pfp_front, drains into pfp_res_q.
module pfp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pfp_pkg::WM_W-1:0]      watermark,
    input  logic [pfp_pkg::SPACE_W-1:0]   spacing,
    input  logic                          cmd_valid,
    input  pfp_pkg::cmd_t                 cmd,
    output logic                          cmd_take,
    input  logic                          res_full,
    output logic                          res_push,
    output pfp_pkg::res_t                 res_data,
    output pfp_pkg::bk_stat_t             stat
);

    localparam int QIDX_W = pfp_pkg::QIDX_W;
    localparam int QCNT_W = pfp_pkg::QCNT_W;
    localparam int TIME_W = pfp_pkg::TIME_W;

    // Pending buffer memory with registered read at the head.
    pfp_pkg::entry_t mem [pfp_pkg::QUEUE_DEPTH];
    pfp_pkg::entry_t rd_reg;
    logic            mem_we;
    logic [QIDX_W-1:0] mem_waddr;
    pfp_pkg::entry_t mem_wdata;

    pfp_pkg::bk_state_t state_reg;
    pfp_pkg::bk_state_t state_next;
    pfp_pkg::run_t      run_reg;
    pfp_pkg::run_t      run_next;
    logic [QIDX_W-1:0]  head_reg;
    logic [QIDX_W-1:0]  head_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               first_reg;
    logic               first_next;
    logic [TIME_W-1:0]  ref_cap_reg;
    logic [TIME_W-1:0]  ref_cap_next;
    logic [TIME_W-1:0]  ref_pres_reg;
    logic [TIME_W-1:0]  ref_pres_next;
    logic signed [63:0] target_reg;
    logic signed [63:0] target_next;
    logic [TIME_W-1:0]  best_time_reg;
    logic [TIME_W-1:0]  best_time_next;
    logic [63:0]        best_gap_reg;
    logic [63:0]        best_gap_next;

    // Working registers without reset.
    pfp_pkg::cmd_t      cmd_reg;
    pfp_pkg::cmd_t      cmd_next;
    pfp_pkg::entry_t    chosen_reg;
    pfp_pkg::entry_t    chosen_next;
    logic signed [63:0] interval_reg;
    logic signed [63:0] interval_next;
    logic [63:0]        gap_reg;
    logic [63:0]        gap_next;

    // Helper values.
    logic [QIDX_W-1:0]  head_inc;
    logic [QCNT_W:0]    tail_sum;
    logic [QIDX_W-1:0]  tail;
    logic               q_full;
    logic [QCNT_W-1:0]  cnt_inc;
    pfp_pkg::entry_t    new_entry;
    pfp_pkg::entry_t    old_entry;
    logic               below;
    logic [63:0]        ideal_sum;
    logic [64:0]        diff_up;
    logic [64:0]        diff_dn;
    logic               take;
    logic [TIME_W-1:0]  win_time;

    // Queue pointer arithmetic.
    always_comb
    begin
        head_inc = (head_reg == QIDX_W'(pfp_pkg::QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        tail_sum = (QCNT_W + 1)'(head_reg) + (QCNT_W + 1)'(count_reg);
        if (tail_sum >= (QCNT_W + 1)'(pfp_pkg::QUEUE_DEPTH))
        begin
            tail = QIDX_W'(tail_sum - (QCNT_W + 1)'(pfp_pkg::QUEUE_DEPTH));
        end
        else
        begin
            tail = QIDX_W'(tail_sum);
        end
        q_full  = (count_reg == QCNT_W'(pfp_pkg::QUEUE_DEPTH));
        cnt_inc = count_reg + 1'b1;
    end

    // The buffer carried by a queue item.
    always_comb
    begin
        new_entry.time_ns   = cmd_reg.time_ns;
        new_entry.buf_id    = cmd_reg.buf_id;
        new_entry.transform = cmd_reg.transform;
        new_entry.fence     = cmd_reg.fence;
        old_entry           = (count_reg == '0) ? new_entry : rd_reg;
    end

    // Pacing arithmetic: ideal time, distance to it, and winner choice.
    always_comb
    begin
        below     = interval_reg < $signed({32'b0, spacing});
        ideal_sum = {1'b0, ref_pres_reg} + $unsigned(interval_reg);
        diff_up   = {2'b00, cmd_reg.time_ns} - {target_reg[63], $unsigned(target_reg)};
        diff_dn   = {target_reg[63], $unsigned(target_reg)} - {2'b00, cmd_reg.time_ns};
        take      = first_reg || (gap_reg < best_gap_reg);
        win_time  = take ? cmd_reg.time_ns : best_time_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfp_pkg::BK_IDLE:
            begin
                if (cmd_valid && !res_full)
                begin
                    state_next = pfp_pkg::BK_EXEC;
                end
            end
            pfp_pkg::BK_EXEC:
            begin
                if (cmd_reg.kind == pfp_pkg::CMD_CAND && run_reg == pfp_pkg::RUN_IDLE &&
                    count_reg != '0)
                begin
                    state_next = pfp_pkg::BK_TARGET;
                end
                else if (cmd_reg.kind == pfp_pkg::CMD_CAND && run_reg == pfp_pkg::RUN_HELD)
                begin
                    state_next = pfp_pkg::BK_GAP;
                end
                else
                begin
                    state_next = pfp_pkg::BK_IDLE;
                end
            end
            pfp_pkg::BK_TARGET: state_next = pfp_pkg::BK_GAP;
            pfp_pkg::BK_GAP:    state_next = pfp_pkg::BK_UPDATE;
            pfp_pkg::BK_UPDATE: state_next = pfp_pkg::BK_IDLE;
            default:            state_next = pfp_pkg::BK_IDLE;
        endcase
    end

    // Datapath and outputs per state.
    always_comb
    begin
        cmd_take       = 1'b0;
        res_push       = 1'b0;
        res_data       = '0;
        mem_we         = 1'b0;
        mem_waddr      = tail;
        mem_wdata      = new_entry;
        run_next       = run_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        ref_cap_next   = ref_cap_reg;
        ref_pres_next  = ref_pres_reg;
        target_next    = target_reg;
        best_time_next = best_time_reg;
        best_gap_next  = best_gap_reg;
        cmd_next       = cmd_reg;
        chosen_next    = chosen_reg;
        interval_next  = interval_reg;
        gap_next       = gap_reg;

        unique case (state_reg)
            pfp_pkg::BK_IDLE:
            begin
                // Take the next item only when its result has a place to go.
                cmd_take = cmd_valid && !res_full;
                if (cmd_take)
                begin
                    cmd_next = cmd;
                end
            end
            pfp_pkg::BK_EXEC:
            begin
                if (cmd_reg.kind == pfp_pkg::CMD_QUEUE)
                begin
                    mem_we = 1'b1;
                    if (q_full)
                    begin
                        // Full store: the oldest buffer leaves, the new one takes its slot.
                        head_next          = head_inc;
                        res_push           = 1'b1;
                        res_data.buf_id    = rd_reg.buf_id;
                        res_data.transform = rd_reg.transform;
                        res_data.fence     = rd_reg.fence;
                        res_data.time_ns   = rd_reg.time_ns;
                        res_data.early     = 1'b1;
                        ref_cap_next       = '0;
                        ref_pres_next      = '0;
                    end
                    else if (8'(cnt_inc) <= 8'(watermark))
                    begin
                        count_next = cnt_inc;
                    end
                    else
                    begin
                        // Over the watermark: release the oldest buffer at once.
                        head_next          = head_inc;
                        res_push           = 1'b1;
                        res_data.buf_id    = old_entry.buf_id;
                        res_data.transform = old_entry.transform;
                        res_data.fence     = old_entry.fence;
                        res_data.time_ns   = old_entry.time_ns;
                        res_data.early     = 1'b1;
                        ref_cap_next       = '0;
                        ref_pres_next      = '0;
                    end
                end
                else
                begin
                    unique case (run_reg)
                        pfp_pkg::RUN_IDLE:
                        begin
                            if (count_reg != '0)
                            begin
                                // Open a run holding the front buffer.
                                chosen_next   = rd_reg;
                                head_next     = head_inc;
                                count_next    = count_reg - 1'b1;
                                interval_next = $signed({1'b0, rd_reg.time_ns}) -
                                                $signed({1'b0, ref_cap_reg});
                                run_next      = pfp_pkg::RUN_HELD;
                                first_next    = 1'b1;
                            end
                            else
                            begin
                                run_next = cmd_reg.last ? pfp_pkg::RUN_IDLE
                                                        : pfp_pkg::RUN_EMPTY;
                            end
                        end
                        pfp_pkg::RUN_HELD:
                        begin
                            first_next = 1'b0;
                        end
                        pfp_pkg::RUN_EMPTY:
                        begin
                            if (cmd_reg.last)
                            begin
                                run_next = pfp_pkg::RUN_IDLE;
                            end
                        end
                        default:
                        begin
                            run_next = pfp_pkg::RUN_IDLE;
                        end
                    endcase
                end
            end
            pfp_pkg::BK_TARGET:
            begin
                // Ideal time from the last present time, or restart at capture time.
                if (below)
                begin
                    if (!interval_reg[63] && ideal_sum[63])
                    begin
                        target_next = $signed(pfp_pkg::TIME_MAX);
                    end
                    else
                    begin
                        target_next = $signed(ideal_sum);
                    end
                end
                else
                begin
                    target_next = $signed({1'b0, chosen_reg.time_ns});
                end
            end
            pfp_pkg::BK_GAP:
            begin
                gap_next = diff_up[64] ? diff_dn[63:0] : diff_up[63:0];
            end
            pfp_pkg::BK_UPDATE:
            begin
                if (take)
                begin
                    best_gap_next  = gap_reg;
                    best_time_next = cmd_reg.time_ns;
                end
                if (cmd_reg.last)
                begin
                    // End of run: emit the held buffer at the winning time.
                    res_push           = 1'b1;
                    res_data.buf_id    = chosen_reg.buf_id;
                    res_data.transform = chosen_reg.transform;
                    res_data.fence     = chosen_reg.fence;
                    res_data.time_ns   = win_time;
                    res_data.early     = 1'b0;
                    ref_cap_next       = chosen_reg.time_ns;
                    ref_pres_next      = win_time;
                    best_gap_next      = '1;
                    run_next           = pfp_pkg::RUN_IDLE;
                end
            end
            default:
            begin
                cmd_take = 1'b0;
            end
        endcase
    end

    assign stat.count = count_reg;
    assign stat.held  = (run_reg == pfp_pkg::RUN_HELD);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfp_pkg::BK_IDLE;
            run_reg       <= pfp_pkg::RUN_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            first_reg     <= 1'b0;
            ref_cap_reg   <= '0;
            ref_pres_reg  <= '0;
            target_reg    <= '0;
            best_time_reg <= '0;
            best_gap_reg  <= '1;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            ref_cap_reg   <= ref_cap_next;
            ref_pres_reg  <= ref_pres_next;
            target_reg    <= target_next;
            best_time_reg <= best_time_next;
            best_gap_reg  <= best_gap_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        chosen_reg   <= chosen_next;
        interval_reg <= interval_next;
        gap_reg      <= gap_next;
    end

    // Pending store: one write port at the tail, registered read at the head.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[head_reg];
    end

endmodule

FILE: hw/rtl/preview_frame_pacer_core.sv
// Top level of the preview frame pacer: register port, front, back and result queue.
// Depends on pfp_pkg, pfp_front, pfp_back, pfp_res_q and the assertion macro header.
//
//  Channel   Handshake             Payload
//  -------   -------------------   ---------------------------------------------------
//  input     push / full           func, time_ns, frame_transform, buffer_id, fence_id,
//                                  last_candidate
//  result    empty / pop           out_buffer_id, out_transform, out_fence_id,
//                                  present_time_ns, early_release
//  config    psel/penable/pwrite   paddr, pwdata, prdata, pready (always high)
//
// The back end handles one item at a time: a queue item or an empty-run candidate
// passes through IDLE and EXEC, a later candidate of a run through IDLE, EXEC, GAP and
// UPDATE, the first candidate of a run also through TARGET for the ideal-time add.
// A two-entry input queue and a two-entry result queue let each side stall alone;
// the back end starts an item only while the result queue has room.
// Reset is asynchronous and needs no clearing pass; the pending store is unset.
`include "preview_frame_pacer_core_macros.svh"
module preview_frame_pacer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pfp_pkg::ADDR_W-1:0]          paddr,
    input  logic [pfp_pkg::DATA_W-1:0]          pwdata,
    output logic [pfp_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                push,
    output logic                                full,
    input  logic                                func,
    input  logic [pfp_pkg::TIME_W-1:0]          time_ns,
    input  logic [pfp_pkg::XFORM_W-1:0]         frame_transform,
    input  logic [pfp_pkg::BUFID_W-1:0]         buffer_id,
    input  logic signed [pfp_pkg::FENCE_W-1:0]  fence_id,
    input  logic                                last_candidate,
    output logic                                empty,
    input  logic                                pop,
    output logic [pfp_pkg::BUFID_W-1:0]         out_buffer_id,
    output logic [pfp_pkg::XFORM_W-1:0]         out_transform,
    output logic signed [pfp_pkg::FENCE_W-1:0]  out_fence_id,
    output logic [pfp_pkg::TIME_W-1:0]          present_time_ns,
    output logic                                early_release
);

    logic [pfp_pkg::WM_W-1:0]    wm_reg;
    logic [pfp_pkg::WM_W-1:0]    wm_next;
    logic [pfp_pkg::SPACE_W-1:0] spacing_reg;
    logic [pfp_pkg::SPACE_W-1:0] spacing_next;
    pfp_pkg::reg_idx_t           reg_idx;
    logic                        cfg_write;

    logic              cmd_valid;
    pfp_pkg::cmd_t     cmd;
    logic              cmd_take;
    logic              res_full;
    logic              res_push;
    pfp_pkg::res_t     res_data;
    pfp_pkg::res_t     res_head;
    pfp_pkg::bk_stat_t bk_stat;

    // Register port: writes complete in the access phase, reads are immediate.
    assign pready    = 1'b1;
    assign reg_idx   = pfp_pkg::reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        wm_next      = wm_reg;
        spacing_next = spacing_reg;
        prdata       = '0;
        unique case (reg_idx)
            pfp_pkg::REG_WATERMARK:
            begin
                prdata = pfp_pkg::DATA_W'(wm_reg);
                if (cfg_write)
                begin
                    wm_next = pwdata[pfp_pkg::WM_W-1:0];
                end
            end
            pfp_pkg::REG_SPACING:
            begin
                prdata = spacing_reg;
                if (cfg_write)
                begin
                    spacing_next = pwdata[pfp_pkg::SPACE_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wm_reg      <= pfp_pkg::WM_RESET;
            spacing_reg <= pfp_pkg::SPACE_RESET;
        end
        else
        begin
            wm_reg      <= wm_next;
            spacing_reg <= spacing_next;
        end
    end

    // Front end: accept and classify.
    pfp_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .func            (func),
        .time_ns         (time_ns),
        .frame_transform (frame_transform),
        .buffer_id       (buffer_id),
        .fence_id        (fence_id),
        .last_candidate  (last_candidate),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_take        (cmd_take)
    );

    // Back end: buffer store and pacing.
    pfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .watermark (wm_reg),
        .spacing   (spacing_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data),
        .stat      (bk_stat)
    );

    // Result queue toward the display side.
    pfp_res_q u_res_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_data (res_data),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .head     (res_head)
    );

    assign out_buffer_id   = res_head.buf_id;
    assign out_transform   = res_head.transform;
    assign out_fence_id    = res_head.fence;
    assign present_time_ns = res_head.time_ns;
    assign early_release   = res_head.early;

    // Checks on the back end and its hand-off to the result queue.
    `PFP_ASSERT_IMP(a_no_res_overflow, res_push, !res_full)
    `PFP_ASSERT_IMP(a_count_bound, 1'b1, bk_stat.count <= pfp_pkg::QUEUE_DEPTH)
    `PFP_ASSERT_IMP(a_take_valid, cmd_take, cmd_valid)
    `PFP_ASSERT_NXT(a_run_closed, res_push && !res_data.early, !bk_stat.held)

endmodule
